// ----- hdl/nfbe_pkg.sv -----
// shared types and constants for the near/far back-reference word expander
package nfbe_pkg;

	localparam int unsigned HISTORY_WORDS_DEF = 4096;
	localparam int unsigned QUEUE_DEPTH_DEF   = 4;

	localparam int unsigned LEN_W  = 14;
	localparam int unsigned POS_W  = 13;
	localparam int unsigned SRC_W  = 17;
	localparam int unsigned WORD_W = 16;

	localparam logic [7:0]       NEAR_TAG  = 8'hA7;
	localparam logic [7:0]       FAR_TAG   = 8'hA8;
	localparam logic [LEN_W-1:0] LEN_RESET = 14'd8192;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_NEAR,
		CMD_FAR
	} cmd_kind_t;

	typedef struct packed {
		logic      start;
		cmd_kind_t kind;
		logic [7:0] count;
		logic [15:0] arg;
	} cmd_t;

	typedef enum logic [1:0] {
		FLT_NONE       = 2'd0,
		FLT_UNWRITTEN  = 2'd1,
		FLT_CLIPPED    = 2'd2
	} fault_t;

	typedef enum logic [2:0] {
		PH_LOW,
		PH_HIGH,
		PH_TAG,
		PH_NEAR,
		PH_FAR_LO,
		PH_FAR_HI
	} phase_t;

	typedef enum logic {
		BK_IDLE,
		BK_COPY
	} back_state_t;

	typedef struct packed {
		logic [3:0][WORD_W-1:0] words;
		logic [2:0]             count;
		logic                   last;
		logic                   done;
		logic [1:0]             fault;
	} result_t;

endpackage

// ----- hdl/nfbe_ifs.sv -----
// request channel interfaces: compressed bytes, expanded words, length register
interface nfbe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_start;

	modport source (output valid, data_byte, stream_start, input ready);
	modport sink (input valid, data_byte, stream_start, output ready);
endinterface

interface nfbe_word_if;
	logic                        valid;
	logic                        ready;
	logic [nfbe_pkg::WORD_W-1:0] word_a;
	logic [nfbe_pkg::WORD_W-1:0] word_b;
	logic [nfbe_pkg::WORD_W-1:0] word_c;
	logic [nfbe_pkg::WORD_W-1:0] word_d;
	logic [2:0]                  word_count;
	logic                        last_of_run;
	logic                        stream_done;
	logic [1:0]                  fault;

	modport source (output valid, word_a, word_b, word_c, word_d, word_count,
		last_of_run, stream_done, fault, input ready);
	modport sink (input valid, word_a, word_b, word_c, word_d, word_count,
		last_of_run, stream_done, fault, output ready);
endinterface

interface nfbe_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [nfbe_pkg::LEN_W-1:0] expanded_bytes;

	modport source (output valid, expanded_bytes, input ready);
	modport sink (input valid, expanded_bytes, output ready);
endinterface

// ----- hdl/nfbe_front.sv -----
// byte parser: turns compressed bytes into literal and copy commands
module nfbe_front (
	input  logic           clk,
	input  logic           arst_n,
	nfbe_byte_if.sink      bytes,
	output logic           push,
	output nfbe_pkg::cmd_t cmd,
	input  logic           full
);
	import nfbe_pkg::*;

	phase_t     phase_q, phase_d, ph;
	logic [7:0] low_q, low_d;
	logic [7:0] tag_q, tag_d;
	logic [7:0] off_q, off_d;
	logic       pend_q, pend_d;
	logic       accept;
	logic       start;

	assign bytes.ready = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOW;
			low_q   <= '0;
			tag_q   <= '0;
			off_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			low_q   <= low_d;
			tag_q   <= tag_d;
			off_q   <= off_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		low_d     = low_q;
		tag_d     = tag_q;
		off_d     = off_q;
		pend_d    = pend_q;
		push      = 1'b0;
		accept    = bytes.valid && !full;
		start     = pend_q || bytes.stream_start;
		ph        = bytes.stream_start ? PH_LOW : phase_q;
		cmd       = '0;
		cmd.start = start;
		cmd.kind  = CMD_LIT;
		cmd.count = low_q;
		if (accept) begin
			pend_d = start;
			unique case (ph)
				PH_LOW: begin
					low_d   = bytes.data_byte;
					phase_d = PH_HIGH;
				end
				PH_HIGH: begin
					if (bytes.data_byte == NEAR_TAG || bytes.data_byte == FAR_TAG) begin
						tag_d = bytes.data_byte;
						if (low_q == '0) begin
							phase_d = PH_TAG;
						end else if (bytes.data_byte == NEAR_TAG) begin
							phase_d = PH_NEAR;
						end else begin
							phase_d = PH_FAR_LO;
						end
					end else begin
						push     = 1'b1;
						cmd.arg  = {bytes.data_byte, low_q};
						phase_d  = PH_LOW;
					end
				end
				PH_TAG: begin
					push    = 1'b1;
					cmd.arg = {tag_q, bytes.data_byte};
					phase_d = PH_LOW;
				end
				PH_NEAR: begin
					push     = 1'b1;
					cmd.kind = CMD_NEAR;
					cmd.arg  = {8'h00, bytes.data_byte};
					phase_d  = PH_LOW;
				end
				PH_FAR_LO: begin
					off_d   = bytes.data_byte;
					phase_d = PH_FAR_HI;
				end
				PH_FAR_HI: begin
					push     = 1'b1;
					cmd.kind = CMD_FAR;
					cmd.arg  = {bytes.data_byte, off_q};
					phase_d  = PH_LOW;
				end
				default: begin
					phase_d = PH_LOW;
				end
			endcase
			if (push) begin
				pend_d = 1'b0;
			end
		end
	end

endmodule

// ----- hdl/nfbe_fifo.sv -----
// command queue between parser and expander
module nfbe_fifo #(
	parameter int unsigned DEPTH = nfbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nfbe_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output nfbe_pkg::cmd_t dout,
	output logic           valid
);
	import nfbe_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// ----- hdl/nfbe_ram.sv -----
// generic single-write, single-read ram with registered read
module nfbe_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/nfbe_back.sv -----
// expander: runs commands against the history and packs words into results
module nfbe_back #(
	parameter int unsigned HISTORY_WORDS = nfbe_pkg::HISTORY_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	nfbe_cfg_if.sink       cfg,
	input  logic           cmd_valid,
	input  nfbe_pkg::cmd_t cmd,
	output logic           pop,
	nfbe_word_if.source    words
);
	import nfbe_pkg::*;

	localparam int unsigned AW = $clog2(HISTORY_WORDS);

	logic [LEN_W-1:0] len_q;
	logic [POS_W-1:0] half, lim, pos_eff, room;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             fin_q, fin_d, fin_eff;
	back_state_t      state_q, state_d;
	logic [SRC_W-1:0] src_q, src_d;
	logic [7:0]       remain_q, remain_d;
	logic             clip_q, clip_d, reach_q, reach_d;
	logic             go;

	// issue stage outputs
	logic             s1_v, s1_lit, s1_ok, s1_fwd, s1_last, s1_done, s1_clip;
	logic [WORD_W-1:0] s1_val;
	logic [AW-1:0]    s1_addr;

	// write stage
	logic             v_s2, lit_s2, ok_s2, fwd_s2, last_s2, done_s2, clip_s2;
	logic [WORD_W-1:0] val_s2;
	logic [AW-1:0]    addr_s2;

	logic             re, we;
	logic [AW-1:0]    raddr;
	logic [WORD_W-1:0] rdata, wd, last_wr_q;

	logic [3:0][WORD_W-1:0] pack_q;
	logic [1:0]       cnt_q;
	logic             bad_q, bad, res_push;
	result_t          res, out_q;
	logic             out_v_q;

	assign cfg.ready = 1'b1;
	assign go        = !out_v_q || words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg.valid) begin
			len_q <= cfg.expanded_bytes;
		end
	end

	always_comb begin
		half = len_q[LEN_W-1:1];
		if (SRC_W'(half) > SRC_W'(HISTORY_WORDS)) begin
			lim = POS_W'(HISTORY_WORDS);
		end else begin
			lim = half;
		end
		pos_eff = cmd.start ? '0 : pos_q;
		fin_eff = cmd.start ? 1'b0 : fin_q;
		room    = (pos_eff < lim) ? lim - pos_eff : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			pos_q    <= '0;
			fin_q    <= 1'b0;
			src_q    <= '0;
			remain_q <= '0;
			clip_q   <= 1'b0;
			reach_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			fin_q    <= fin_d;
			src_q    <= src_d;
			remain_q <= remain_d;
			clip_q   <= clip_d;
			reach_q  <= reach_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		fin_d    = fin_q;
		src_d    = src_q;
		remain_d = remain_q;
		clip_d   = clip_q;
		reach_d  = reach_q;
		pop      = 1'b0;
		s1_v     = 1'b0;
		s1_lit   = 1'b0;
		s1_ok    = 1'b0;
		s1_fwd   = 1'b0;
		s1_last  = 1'b0;
		s1_done  = 1'b0;
		s1_clip  = 1'b0;
		s1_val   = cmd.arg;
		s1_addr  = AW'(pos_q);
		re       = 1'b0;
		raddr    = src_q[AW-1:0];
		if (go) begin
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_valid) begin
						pop   = 1'b1;
						pos_d = pos_eff;
						fin_d = fin_eff;
						if (!fin_eff) begin
							if (room == '0) begin
								fin_d = 1'b1;
							end else if (cmd.kind == CMD_NEAR || cmd.kind == CMD_FAR) begin
								src_d = (cmd.kind == CMD_NEAR)
									? SRC_W'(pos_eff) - SRC_W'(cmd.arg[7:0])
									: SRC_W'(cmd.arg);
								if (POS_W'(cmd.count) > room) begin
									remain_d = room[7:0];
									clip_d   = 1'b1;
									reach_d  = 1'b1;
								end else begin
									remain_d = cmd.count;
									clip_d   = 1'b0;
									reach_d  = (POS_W'(cmd.count) == room);
								end
								state_d = BK_COPY;
							end else begin
								s1_v    = 1'b1;
								s1_lit  = 1'b1;
								s1_last = 1'b1;
								s1_done = (room == POS_W'(1));
								s1_addr = AW'(pos_eff);
								pos_d   = pos_eff + POS_W'(1);
								if (room == POS_W'(1)) begin
									fin_d = 1'b1;
								end
							end
						end
					end
				end
				BK_COPY: begin
					s1_v     = 1'b1;
					s1_ok    = !src_q[SRC_W-1] && (src_q < SRC_W'(pos_q));
					re       = s1_ok;
					s1_fwd   = v_s2 && (raddr == addr_s2);
					s1_last  = (remain_q == 8'd1);
					s1_done  = s1_last && reach_q;
					s1_clip  = s1_last && clip_q;
					pos_d    = pos_q + POS_W'(1);
					src_d    = src_q + SRC_W'(1);
					remain_d = remain_q - 8'd1;
					if (s1_last) begin
						state_d = BK_IDLE;
						if (reach_q) begin
							fin_d = 1'b1;
						end
					end
				end
				default: begin
					state_d = BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (go) begin
			v_s2 <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			lit_s2  <= s1_lit;
			ok_s2   <= s1_ok;
			fwd_s2  <= s1_fwd;
			last_s2 <= s1_last;
			done_s2 <= s1_done;
			clip_s2 <= s1_clip;
			val_s2  <= s1_val;
			addr_s2 <= s1_addr;
		end
	end

	nfbe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (HISTORY_WORDS)
	) u_history (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s2),
		.wdata (wd),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		if (lit_s2) begin
			wd = val_s2;
		end else if (!ok_s2) begin
			wd = '0;
		end else if (fwd_s2) begin
			wd = last_wr_q;
		end else begin
			wd = rdata;
		end
		we            = go && v_s2;
		bad           = !lit_s2 && !ok_s2;
		res_push      = v_s2 && (cnt_q == 2'd3 || last_s2);
		res.words     = pack_q;
		res.words[cnt_q] = wd;
		res.count     = 3'(cnt_q) + 3'd1;
		res.last      = last_s2;
		res.done      = done_s2;
		if (clip_s2) begin
			res.fault = FLT_CLIPPED;
		end else if (bad_q || bad) begin
			res.fault = FLT_UNWRITTEN;
		end else begin
			res.fault = FLT_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			last_wr_q <= wd;
		end
		if (go && res_push) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q  <= '0;
			cnt_q   <= '0;
			bad_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else if (go) begin
			out_v_q <= res_push;
			if (v_s2) begin
				if (res_push) begin
					pack_q <= '0;
					cnt_q  <= '0;
					bad_q  <= 1'b0;
				end else begin
					pack_q[cnt_q] <= wd;
					cnt_q         <= cnt_q + 2'd1;
					bad_q         <= bad_q || bad;
				end
			end
		end
	end

	assign words.valid       = out_v_q;
	assign words.word_a      = out_q.words[0];
	assign words.word_b      = out_q.words[1];
	assign words.word_c      = out_q.words[2];
	assign words.word_d      = out_q.words[3];
	assign words.word_count  = out_q.count;
	assign words.last_of_run = out_q.last;
	assign words.stream_done = out_q.done;
	assign words.fault       = out_q.fault;

endmodule

// ----- hdl/near_far_backref_word_expander_top.sv -----
// Near/far back-reference word expander. Compressed bytes are taken one per cycle while the
// four-entry command queue has room; the parser needs two to four bytes per command. The
// expander handles a literal as it takes the command; a copy takes the command, then issues
// its words one by one, reading the history memory for each source already written. Results
// carry up to four words and are registered from the write stage of the word that closes them;
// a stalled output freezes the expander while the parser keeps filling the queue. No clearing
// pass after reset: history words count as written only below the current stream position.
module near_far_backref_word_expander_top #(
	parameter int unsigned HISTORY_WORDS = nfbe_pkg::HISTORY_WORDS_DEF,
	parameter int unsigned QUEUE_DEPTH   = nfbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nfbe_byte_if.sink   bytes,
	nfbe_word_if.source words,
	nfbe_cfg_if.sink    cfg
);
	import nfbe_pkg::*;

	logic push, full, pop, cmd_valid;
	cmd_t cmd_in, cmd_out;

	nfbe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.push   (push),
		.cmd    (cmd_in),
		.full   (full)
	);

	nfbe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd_in),
		.full   (full),
		.pop    (pop),
		.dout   (cmd_out),
		.valid  (cmd_valid)
	);

	nfbe_back #(
		.HISTORY_WORDS (HISTORY_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.pop       (pop),
		.words     (words)
	);

endmodule

// ----- hdl/nfbe_checker.sv -----
// port-level checks on the result channel, bound to the top level
module nfbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] word_a,
	input logic [15:0] word_b,
	input logic [15:0] word_c,
	input logic [15:0] word_d,
	input logic [2:0]  word_count,
	input logic        last_of_run,
	input logic        stream_done,
	input logic [1:0]  fault
);
	import nfbe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({word_a, word_b, word_c, word_d,
			word_count, last_of_run, stream_done, fault}))
		else $error("result changed while stalled");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_count >= 3'd1 && word_count <= 3'd4)
		else $error("word count out of range");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault == FLT_CLIPPED || stream_done) |->
			last_of_run && (fault != FLT_CLIPPED || stream_done))
		else $error("clip or done flag not on closing result");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (word_count >= 3'd4 || word_d == 16'd0)
			&& (word_count >= 3'd3 || word_c == 16'd0)
			&& (word_count >= 3'd2 || word_b == 16'd0))
		else $error("unused word not zero");

endmodule

bind near_far_backref_word_expander_top nfbe_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (words.valid),
	.out_ready   (words.ready),
	.word_a      (words.word_a),
	.word_b      (words.word_b),
	.word_c      (words.word_c),
	.word_d      (words.word_d),
	.word_count  (words.word_count),
	.last_of_run (words.last_of_run),
	.stream_done (words.stream_done),
	.fault       (words.fault)
);

// ----- tb/tb.sv -----
// testbench for the near/far back-reference word expander: byte stream in, packed words checked
module tb;
	import nfbe_pkg::*;

	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned SETTLE_CYCLES   = 600;
	localparam int unsigned WATCHDOG_CYCLES = 5000;

	typedef struct packed {
		logic [7:0] value;
		logic       begins_stream;
	} compressed_byte_t;

	typedef struct packed {
		logic [3:0][WORD_W-1:0] words;
		logic [2:0]             count;
		logic                   last;
		logic                   done;
		logic [1:0]             fault;
	} word_group_t;

	logic clk = 1'b0;
	logic arst_n;

	nfbe_byte_if byte_ch ();
	nfbe_word_if word_ch ();
	nfbe_cfg_if  cfg_ch ();

	near_far_backref_word_expander_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_ch),
		.words(word_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// expansion state
	logic [WORD_W-1:0] hist_mem [HISTORY_WORDS_DEF];
	phase_t            parse_ph;
	logic [7:0]        low_q;
	logic [7:0]        tag_q;
	logic [7:0]        far_lo_q;
	int unsigned       wpos;
	bit                stream_finished;
	logic [LEN_W-1:0]  len_bytes;
	logic [WORD_W-1:0] run_vals [$];
	bit                run_unwritten [$];
	bit                run_clip;
	bit                run_hit;
	word_group_t       expected_groups [$];

	// stimulus and handshake state
	compressed_byte_t pending_bytes [$];
	compressed_byte_t next_item;
	int unsigned      bytes_queued;
	int unsigned      gen_pos;
	bit               start_next;
	int unsigned      burst_left;
	int unsigned      gap_left;
	bit               hold_request = 1'b0;
	int unsigned      hold_left;
	logic [15:0]      stall_pattern;
	int unsigned      pattern_left;
	int unsigned      mismatch_count;
	int unsigned      quiet_cycles;

	function automatic int unsigned word_limit();
		int unsigned w;
		w = int'(len_bytes) >> 1;
		return (w > HISTORY_WORDS_DEF) ? HISTORY_WORDS_DEF : w;
	endfunction

	task automatic store_word(input logic [WORD_W-1:0] v, input bit bad);
		if (wpos >= word_limit()) begin
			stream_finished = 1'b1;
			return;
		end
		hist_mem[wpos] = v;
		wpos++;
		run_vals.push_back(v);
		run_unwritten.push_back(bad);
		if (wpos >= word_limit()) begin
			stream_finished = 1'b1;
			run_hit = 1'b1;
		end
	endtask

	task automatic copy_run(input int src, input int unsigned n);
		int s;
		logic [WORD_W-1:0] v;
		bit bad;
		for (int unsigned i = 0; i < n; i++) begin
			if (wpos >= word_limit()) begin
				run_clip = 1'b1;
				stream_finished = 1'b1;
				return;
			end
			s = src + int'(i);
			if (s >= 0 && s < int'(wpos)) begin
				v = hist_mem[s];
				bad = 1'b0;
			end else begin
				v = '0;
				bad = 1'b1;
			end
			store_word(v, bad);
		end
	endtask

	task automatic expand_byte(input logic [7:0] b, input logic start);
		int unsigned nres;
		int unsigned cnt;
		bit bad;
		word_group_t grp;
		if (start) begin
			wpos = 0;
			parse_ph = PH_LOW;
			stream_finished = 1'b0;
		end
		if (stream_finished)
			return;
		run_vals.delete();
		run_unwritten.delete();
		run_clip = 1'b0;
		run_hit = 1'b0;
		case (parse_ph)
			PH_LOW: begin
				low_q = b;
				parse_ph = PH_HIGH;
			end
			PH_HIGH: begin
				if (b == NEAR_TAG || b == FAR_TAG) begin
					tag_q = b;
					if (low_q == 8'd0)
						parse_ph = PH_TAG;
					else if (b == NEAR_TAG)
						parse_ph = PH_NEAR;
					else
						parse_ph = PH_FAR_LO;
				end else begin
					store_word({b, low_q}, 1'b0);
					parse_ph = PH_LOW;
				end
			end
			PH_TAG: begin
				store_word({tag_q, b}, 1'b0);
				parse_ph = PH_LOW;
			end
			PH_NEAR: begin
				copy_run(int'(wpos) - int'(b), low_q);
				parse_ph = PH_LOW;
			end
			PH_FAR_LO: begin
				far_lo_q = b;
				parse_ph = PH_FAR_HI;
			end
			PH_FAR_HI: begin
				copy_run(int'({b, far_lo_q}), low_q);
				parse_ph = PH_LOW;
			end
			default: begin
				parse_ph = PH_LOW;
			end
		endcase
		nres = (run_vals.size() + 3) / 4;
		for (int unsigned r = 0; r < nres; r++) begin
			cnt = run_vals.size() - 4 * r;
			if (cnt > 4)
				cnt = 4;
			bad = 1'b0;
			grp = '0;
			for (int unsigned k = 0; k < cnt; k++) begin
				grp.words[k] = run_vals[4 * r + k];
				bad |= run_unwritten[4 * r + k];
			end
			grp.count = 3'(cnt);
			grp.last = (r + 1 == nres);
			grp.done = grp.last && run_hit;
			if (grp.last && run_clip)
				grp.fault = FLT_CLIPPED;
			else if (bad)
				grp.fault = FLT_UNWRITTEN;
			else
				grp.fault = FLT_NONE;
			expected_groups.push_back(grp);
		end
	endtask

	task automatic check_group();
		word_group_t want;
		if (expected_groups.size() == 0) begin
			if (mismatch_count < 10)
				$display("unexpected result: a=%h b=%h c=%h d=%h n=%0d last=%0b done=%0b fault=%0d",
					word_ch.word_a, word_ch.word_b, word_ch.word_c, word_ch.word_d,
					word_ch.word_count, word_ch.last_of_run, word_ch.stream_done, word_ch.fault);
			mismatch_count++;
			return;
		end
		want = expected_groups.pop_front();
		if (want.words[0] !== word_ch.word_a || want.words[1] !== word_ch.word_b ||
				want.words[2] !== word_ch.word_c || want.words[3] !== word_ch.word_d ||
				want.count !== word_ch.word_count || want.last !== word_ch.last_of_run ||
				want.done !== word_ch.stream_done || want.fault !== word_ch.fault) begin
			if (mismatch_count < 10)
				$display({"result mismatch: expected a=%h b=%h c=%h d=%h n=%0d last=%0b done=%0b",
					" fault=%0d, got a=%h b=%h c=%h d=%h n=%0d last=%0b done=%0b fault=%0d"},
					want.words[0], want.words[1], want.words[2], want.words[3], want.count,
					want.last, want.done, want.fault,
					word_ch.word_a, word_ch.word_b, word_ch.word_c, word_ch.word_d,
					word_ch.word_count, word_ch.last_of_run, word_ch.stream_done, word_ch.fault);
			mismatch_count++;
		end
	endtask

	// byte driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data_byte <= '0;
			byte_ch.stream_start <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				expand_byte(byte_ch.data_byte, byte_ch.stream_start);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (gap_left != 0 || pending_bytes.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					byte_ch.valid <= 1'b0;
				end else begin
					next_item = pending_bytes.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.data_byte <= next_item.value;
					byte_ch.stream_start <= next_item.begins_stream;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// result monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_ch.ready <= 1'b0;
			hold_left = 0;
			stall_pattern = 16'hffff;
			pattern_left = 1;
		end else begin
			if (word_ch.valid && word_ch.ready)
				check_group();
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				word_ch.ready <= 1'b0;
			end else begin
				pattern_left--;
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(8, 120);
					stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
				end
				stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
				word_ch.ready <= stall_pattern[0];
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (word_ch.valid && word_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b);
		compressed_byte_t it;
		it.value = b;
		it.begins_stream = start_next;
		start_next = 1'b0;
		pending_bytes.push_back(it);
		bytes_queued++;
	endtask

	task automatic new_stream();
		start_next = 1'b1;
		gen_pos = 0;
	endtask

	task automatic push_literal(input logic [15:0] w);
		if (w[15:8] == NEAR_TAG || w[15:8] == FAR_TAG) begin
			push_byte(8'h00);
			push_byte(w[15:8]);
			push_byte(w[7:0]);
		end else begin
			push_byte(w[7:0]);
			push_byte(w[15:8]);
		end
		gen_pos++;
	endtask

	task automatic push_near(input logic [7:0] cnt, input logic [7:0] off);
		push_byte(cnt);
		push_byte(NEAR_TAG);
		push_byte(off);
		gen_pos += cnt;
	endtask

	task automatic push_far(input logic [7:0] cnt, input logic [15:0] off);
		push_byte(cnt);
		push_byte(FAR_TAG);
		push_byte(off[7:0]);
		push_byte(off[15:8]);
		gen_pos += cnt;
	endtask

	task automatic push_random_cmd();
		int unsigned pick;
		int unsigned cnt;
		int unsigned off;
		pick = $urandom_range(0, 99);
		cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
		if (pick < 40) begin
			push_literal(16'($urandom_range(0, 65535)));
		end else if (pick < 50) begin
			push_literal({($urandom_range(0, 1) != 0) ? NEAR_TAG : FAR_TAG,
				8'($urandom_range(0, 255))});
		end else if (pick < 72) begin
			if (gen_pos != 0 && $urandom_range(0, 7) != 0)
				off = $urandom_range(1, (gen_pos > 255) ? 255 : gen_pos);
			else
				off = $urandom_range(0, 255);
			push_near(8'(cnt), 8'(off));
		end else if (pick < 90) begin
			if (gen_pos != 0 && $urandom_range(0, 7) != 0)
				off = $urandom_range(0, (gen_pos > 65536) ? 65535 : gen_pos - 1);
			else
				off = $urandom_range(0, 65535);
			push_far(8'(cnt), 16'(off));
		end else if (pick < 96) begin
			// stray byte, knocks the parser out of step
			if ($urandom_range(0, 3) == 0)
				new_stream();
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			// cut-off command, then a fresh stream
			push_byte(8'($urandom_range(1, 255)));
			push_byte(($urandom_range(0, 1) != 0) ? NEAR_TAG : FAR_TAG);
			new_stream();
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || byte_ch.valid || expected_groups.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.expanded_bytes <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		len_bytes = v;
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int unsigned phase_base;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.stream_start = 1'b0;
		word_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.expanded_bytes = LEN_RESET;
		arst_n = 1'b0;
		parse_ph = PH_LOW;
		low_q = '0;
		tag_q = '0;
		far_lo_q = '0;
		wpos = 0;
		stream_finished = 1'b0;
		len_bytes = LEN_RESET;
		mismatch_count = 0;
		bytes_queued = 0;
		gen_pos = 0;
		start_next = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		new_stream();
		push_literal(16'h0000);
		push_literal(16'hffff);
		push_literal({NEAR_TAG, 8'h5a});
		push_literal({FAR_TAG, 8'hff});
		push_near(8'd3, 8'd2);
		push_near(8'd2, 8'd0);
		push_near(8'd1, 8'd200);
		push_far(8'd5, 16'h0000);
		push_far(8'd2, 16'hffff);
		push_near(8'd255, 8'd1);
		push_byte(8'h04);
		push_byte(NEAR_TAG);
		wait_idle();

		// copy runs into the length limit
		write_len(14'd20);
		new_stream();
		push_literal(16'h1234);
		push_near(8'd20, 8'd1);
		push_literal(16'h5555);
		wait_idle();

		// zero length drops everything
		write_len(14'd0);
		new_stream();
		push_literal(16'habcd);
		push_literal(16'h0102);
		wait_idle();

		// limit lowered under the current position
		write_len(14'h3fff);
		new_stream();
		push_literal(16'h8001);
		push_near(8'd29, 8'd1);
		wait_idle();
		write_len(14'd20);
		push_literal(16'h7777);
		push_literal(16'h6666);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0, 3: write_len(14'h3fff);
				4, 6: write_len(14'($urandom_range(20, 200)));
				7: write_len(LEN_RESET);
				default: write_len(14'($urandom_range(0, 16383)));
			endcase
			if (ph == 3)
				hold_request = 1'b1;
			phase_base = bytes_queued;
			while (bytes_queued - phase_base < 20) begin
				new_stream();
				repeat ($urandom_range(3, 20)) push_random_cmd();
			end
			wait_idle();
		end

		if (mismatch_count == 0 && expected_groups.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/nfbe_pkg.sv
hdl/nfbe_ifs.sv
hdl/nfbe_front.sv
hdl/nfbe_fifo.sv
hdl/nfbe_ram.sv
hdl/nfbe_back.sv
hdl/near_far_backref_word_expander_top.sv
hdl/nfbe_checker.sv
tb/tb.sv
